/* rtl/bf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_pkg
// shared constants and types of the 3x3 box filter stream core
// ----------------------------------------------------------------------------
package bf_pkg;

    localparam int MAX_WIDTH    = 4096;
    localparam int PIX_W        = 16;
    localparam int COL_W        = 12;
    localparam int ROW_W        = 16;
    localparam int MEAN_W       = 24;
    localparam int WIDTH_REG_W  = 13;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_IDX_W    = 1;

    localparam int LS_AW        = $clog2(MAX_WIDTH);
    localparam int LS_DW        = 2 * PIX_W;
    localparam int WIN_N        = 3;
    localparam int COLSUM_W     = PIX_W + 2;
    localparam int WINSUM_W     = PIX_W + 4;

    // floor(sum * 256 / 9) = (sum * ceil(2^33 / 9)) >> 25
    localparam int RECIP_W      = 30;
    localparam logic [RECIP_W-1:0] RECIP = 30'd954437177;
    localparam int RECIP_SHIFT  = 25;
    localparam int PROD_W       = WINSUM_W + RECIP_W;

    localparam logic [WIDTH_REG_W-1:0]  MIN_WIDTH     = 13'd3;
    localparam logic [WIDTH_REG_W-1:0]  MAX_WIDTH_VAL = 13'd4096;
    localparam logic [HEIGHT_REG_W-1:0] MIN_HEIGHT    = 16'd3;
    localparam logic [WIDTH_REG_W-1:0]  RST_WIDTH     = 13'd4096;
    localparam logic [HEIGHT_REG_W-1:0] RST_HEIGHT    = 16'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [LS_AW-1:0] col;
        logic             emit;
        logic             last;
        logic [ROW_W-1:0] out_row;
        logic [COL_W-1:0] out_col;
    } pix_info_t;

endpackage

/* rtl/bf_pix_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_pix_if
// pixel input channel: valid/ready with pixel and frame start mark
// ----------------------------------------------------------------------------
interface bf_pix_if;

    logic                      valid;
    logic                      ready;
    logic [bf_pkg::PIX_W-1:0]  pixel;
    logic                      frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink   (input valid, input pixel, input frame_start, output ready);

endinterface

/* rtl/bf_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_res_if
// result channel: valid/ready with window mean and interior position
// ----------------------------------------------------------------------------
interface bf_res_if;

    logic                      valid;
    logic                      ready;
    logic [bf_pkg::MEAN_W-1:0] mean_value;
    logic [bf_pkg::ROW_W-1:0]  out_row;
    logic [bf_pkg::COL_W-1:0]  out_col;
    logic                      last;

    modport source (output valid, output mean_value, output out_row, output out_col,
                    output last, input ready);
    modport sink   (input valid, input mean_value, input out_row, input out_col,
                    input last, output ready);

endinterface

/* rtl/box_filter_3x3_stream_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_stream_core
// 3x3 mean filter over a raster pixel stream
// ----------------------------------------------------------------------------
// pix carries one pixel per transfer in raster order; frame_start marks row 0,
// column 0 and clears the position counters, which also wrap on their own at
// the configured width and height. every pixel at row >= 2 and column >= 2
// closes the window of an interior pixel and yields one transfer on res:
// floor(sum * 256 / 9) with 8 fraction bits, its interior row and column, and
// last on the final result of the frame. the outer ring yields nothing.
// throughput is one pixel per cycle until a stalled res fills the pipeline,
// set by the single-port-per-side line store ram (read at accept, written
// back as the pixel leaves the first stage) and the chain of three column
// cells. a result passes through the first stage, the column cells, the sum
// register and the output register, and transfers once res is ready. a
// stalled res holds the output register; the stages ahead keep filling, and
// pix.ready drops only once all four pipeline registers are full.
// reset clears the window to zero, the position to row 0, column 0 and sets
// width and height to 4096; line store contents are not cleared.
// cfg_we writes register cfg_index (0 width, 1 height) from cfg_wdata.
// ----------------------------------------------------------------------------
module box_filter_3x3_stream_core (
    input  logic                           clk,
    input  logic                           rst_n,
    bf_pix_if.sink                         pix,
    bf_res_if.source                       res,
    input  logic                           cfg_we,
    input  logic [bf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bf_pkg::*;

    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [WIDTH_REG_W-1:0]  w_eff;
    logic [HEIGHT_REG_W-1:0] h_eff;

    logic [LS_AW-1:0]        col_reg;
    logic [LS_AW-1:0]        col_next;
    logic [ROW_W-1:0]        row_reg;
    logic [ROW_W-1:0]        row_next;
    logic [LS_AW-1:0]        cur_col;
    logic [ROW_W-1:0]        cur_row;
    logic [WIDTH_REG_W-1:0]  col_inc;
    logic [ROW_W:0]          row_inc;

    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic                    out_valid_reg;
    pix_info_t               s1_reg;
    pix_info_t               s1_next;
    pix_info_t               s2_reg;
    logic [WINSUM_W-1:0]     sum_reg;
    logic [ROW_W-1:0]        s3_row_reg;
    logic [COL_W-1:0]        s3_col_reg;
    logic                    s3_last_reg;
    logic [MEAN_W-1:0]       mean_reg;
    logic [ROW_W-1:0]        out_row_reg;
    logic [COL_W-1:0]        out_col_reg;
    logic                    out_last_reg;

    logic                    en_out;
    logic                    en3;
    logic                    en2;
    logic                    en1;
    logic                    acc;
    logic                    adv1;

    logic [LS_DW-1:0]        ls_rd_data;
    logic [LS_DW-1:0]        ls_wr_data;
    logic [PIX_W-1:0]        up_pix;
    logic [PIX_W-1:0]        mid_pix;
    logic [COLSUM_W-1:0]     new_col_sum;
    logic [COLSUM_W-1:0]     cell_in  [WIN_N];
    logic [COLSUM_W-1:0]     cell_sum [WIN_N];
    logic [WINSUM_W-1:0]     win_sum;
    logic [PROD_W-1:0]       product;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WIDTH_REG_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_eff = (width_reg < MIN_WIDTH) ? MIN_WIDTH :
                   (width_reg > MAX_WIDTH_VAL) ? MAX_WIDTH_VAL : width_reg;
    assign h_eff = (height_reg < MIN_HEIGHT) ? MIN_HEIGHT : height_reg;

    // pipeline flow
    assign en_out = !out_valid_reg || res.ready;
    assign en3    = !v3_reg || en_out;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign acc    = pix.valid && en1;
    assign adv1   = v1_reg && en2;

    assign pix.ready = en1;

    // position and window classification at accept
    assign cur_col = pix.frame_start ? '0 : col_reg;
    assign cur_row = pix.frame_start ? '0 : row_reg;
    assign col_inc = {1'b0, cur_col} + 1'b1;
    assign row_inc = {1'b0, cur_row} + 1'b1;

    always_comb
    begin
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[LS_AW-1:0];
            row_next = cur_row;
        end
    end

    always_comb
    begin
        s1_next.pixel   = pix.pixel;
        s1_next.col     = cur_col;
        s1_next.emit    = (cur_row >= 16'd2) && (cur_col >= 12'd2) && (cur_row < h_eff)
                          && ({1'b0, cur_col} < w_eff);
        s1_next.last    = (cur_row == h_eff - 1'b1) && ({1'b0, cur_col} == w_eff - 1'b1);
        s1_next.out_row = cur_row - 16'd2;
        s1_next.out_col = cur_col - 12'd2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line stores: upper in the high half, middle in the low half
    assign up_pix     = ls_rd_data[LS_DW-1:PIX_W];
    assign mid_pix    = ls_rd_data[PIX_W-1:0];
    assign ls_wr_data = {mid_pix, s1_reg.pixel};

    bf_line_store u_line_store (
        .clk     (clk),
        .rd_en   (acc),
        .rd_addr (cur_col),
        .wr_en   (adv1),
        .wr_addr (s1_reg.col),
        .wr_data (ls_wr_data),
        .rd_data (ls_rd_data)
    );

    // window as a chain of column cells, newest at the top index
    assign new_col_sum = COLSUM_W'(up_pix) + COLSUM_W'(mid_pix) + COLSUM_W'(s1_reg.pixel);

    for (genvar i = 0; i < WIN_N; i++)
    begin : g_cell
        if (i == WIN_N - 1)
        begin : g_newest
            assign cell_in[i] = new_col_sum;
        end
        else
        begin : g_older
            assign cell_in[i] = cell_sum[i+1];
        end

        bf_col_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift      (adv1),
            .col_sum_in (cell_in[i]),
            .col_sum    (cell_sum[i])
        );
    end

    assign win_sum = WINSUM_W'(cell_sum[0]) + WINSUM_W'(cell_sum[1]) + WINSUM_W'(cell_sum[2]);
    assign product = PROD_W'(sum_reg) * PROD_W'(RECIP);

    // stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= acc;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg && s2_reg.emit;
            end
            if (en_out)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_reg <= s1_next;
        end
        if (adv1)
        begin
            s2_reg <= s1_reg;
        end
        if (en3)
        begin
            sum_reg     <= win_sum;
            s3_row_reg  <= s2_reg.out_row;
            s3_col_reg  <= s2_reg.out_col;
            s3_last_reg <= s2_reg.last;
        end
        if (en_out)
        begin
            mean_reg     <= product[RECIP_SHIFT +: MEAN_W];
            out_row_reg  <= s3_row_reg;
            out_col_reg  <= s3_col_reg;
            out_last_reg <= s3_last_reg;
        end
    end

    assign res.valid      = out_valid_reg;
    assign res.mean_value = mean_reg;
    assign res.out_row    = out_row_reg;
    assign res.out_col    = out_col_reg;
    assign res.last       = out_last_reg;

    // input stalls only with every stage full and the output stalled
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pix.ready |-> (v1_reg && v2_reg && v3_reg && out_valid_reg && !res.ready))
        else $error("input stalled with a free stage");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> v1_reg)
        else $error("accepted pixel not in first stage");

    a_frame_start_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && pix.frame_start) |=> (col_reg == 12'd1 && row_reg == 16'd0))
        else $error("frame start did not restart position");

endmodule

/* rtl/bf_line_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_line_store
// two line stores packed into one ram word, registered read with bypass
// ----------------------------------------------------------------------------
module bf_line_store (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [bf_pkg::LS_AW-1:0]  rd_addr,
    input  logic                      wr_en,
    input  logic [bf_pkg::LS_AW-1:0]  wr_addr,
    input  logic [bf_pkg::LS_DW-1:0]  wr_data,
    output logic [bf_pkg::LS_DW-1:0]  rd_data
);
    import bf_pkg::*;

    logic [LS_DW-1:0] ram_reg [MAX_WIDTH];
    logic [LS_DW-1:0] rd_data_reg;
    logic [LS_DW-1:0] fwd_data_reg;
    logic             fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= ram_reg[rd_addr];
            fwd_data_reg <= wr_data;
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : rd_data_reg;

endmodule

/* rtl/bf_col_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bf_col_cell
// one window column: holds its column sum and passes it to the older neighbor
// ----------------------------------------------------------------------------
module bf_col_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         shift,
    input  logic [bf_pkg::COLSUM_W-1:0]  col_sum_in,
    output logic [bf_pkg::COLSUM_W-1:0]  col_sum
);
    import bf_pkg::*;

    logic [COLSUM_W-1:0] sum_reg;
    logic [COLSUM_W-1:0] sum_next;

    assign sum_next = shift ? col_sum_in : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    assign col_sum = sum_reg;

endmodule

/* sim/tb_box_filter_3x3_stream_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_filter_3x3_stream_core
// self-checking bench for the 3x3 mean filter stream core
// ----------------------------------------------------------------------------
// a short table of hand-checked frames runs first, then random pixel streams
// over a set of image geometries: small frames, saturated width and height,
// geometry changed in the middle of a frame and the start of a frame at the
// widest line. every accepted pixel goes through a local model of the line
// stores and the window; each result transfer is compared field by field with
// the oldest predicted mean. idling on the pixel side and stalls on the result
// side vary from phase to phase.
// ----------------------------------------------------------------------------
module tb_box_filter_3x3_stream_core;

    import bf_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 12;
    localparam int WIN_PIXELS    = WIN_N * WIN_N;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } mean_res_t;

    typedef struct packed {
        logic [PIX_W-1:0]  pixel;
        logic              frame_start;
        logic              typed;
        logic [MEAN_W-1:0] mean;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } smoke_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bf_pix_if pix ();
    bf_res_if res ();

    box_filter_3x3_stream_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix.sink),
        .res       (res.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // model state
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [PIX_W-1:0]        upper_line  [MAX_WIDTH];
    logic [PIX_W-1:0]        middle_line [MAX_WIDTH];
    logic [PIX_W-1:0]        win         [WIN_PIXELS];
    int unsigned             col_pos;
    int unsigned             row_pos;

    mean_res_t   expected_means [$];
    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned pixels_sent;
    int unsigned means_checked;
    int unsigned geometries;
    int unsigned mismatches;
    int unsigned cycle_count;

    // 3x3 frames: all ones, then a ramp that starts on the wrap of the position
    smoke_row_t smoke_rows [18] = '{
        '{16'hFFFF, 1'b1, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b1, 24'hFFFF00, 16'd0, 12'd0, 1'b1},
        '{16'd0,    1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'd1,    1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'd2,    1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'd3,    1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'd4,    1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'd5,    1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'd6,    1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'd7,    1'b0, 1'b0, 24'h0, 16'd0, 12'd0, 1'b0},
        '{16'd8,    1'b0, 1'b1, 24'd1024, 16'd0, 12'd0, 1'b1}
    };

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("mismatch: %s", msg);
    endtask

    task automatic reset_model();
        width_reg  = RST_WIDTH;
        height_reg = RST_HEIGHT;
        foreach (upper_line[i])
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        foreach (win[i])
            win[i] = '0;
        col_pos = 0;
        row_pos = 0;
    endtask

    // advances the model by one pixel; returns 1 when the pixel closes a window
    function automatic bit mean_of_window(input logic [PIX_W-1:0] px, input logic fs,
                                          output mean_res_t r);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      rw;
        int unsigned      k;
        longint unsigned  s;
        logic [PIX_W-1:0] up_px;
        logic [PIX_W-1:0] mid_px;
        bit               emits;

        w = width_reg;
        if (w < MIN_WIDTH)
            w = MIN_WIDTH;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = (height_reg < MIN_HEIGHT) ? MIN_HEIGHT : height_reg;
        up_px  = '0;
        mid_px = '0;
        r      = '0;
        emits  = 1'b0;

        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c  = col_pos;
        rw = row_pos;

        if (c < MAX_WIDTH)
        begin
            up_px          = upper_line[c];
            mid_px         = middle_line[c];
            upper_line[c]  = mid_px;
            middle_line[c] = px;
        end

        for (k = 0; k < WIN_N; k++)
        begin
            win[k * WIN_N]     = win[k * WIN_N + 1];
            win[k * WIN_N + 1] = win[k * WIN_N + 2];
        end
        win[2] = up_px;
        win[5] = mid_px;
        win[8] = px;

        if (rw >= 2 && c >= 2 && rw < h && c < w)
        begin
            s = 0;
            for (k = 0; k < WIN_PIXELS; k++)
                s += win[k];
            r.mean = MEAN_W'((s * 256) / WIN_PIXELS);
            r.row  = ROW_W'(rw - 2);
            r.col  = COL_W'(c - 2);
            r.last = (rw == h - 1) && (c == w - 1);
            emits  = 1'b1;
        end

        c++;
        if (c >= w)
        begin
            c = 0;
            rw++;
            if (rw >= h)
                rw = 0;
        end
        col_pos = c;
        row_pos = rw;
        return emits;
    endfunction

    task automatic set_geometry(input logic [CFG_DATA_W-1:0] wval,
                                input logic [CFG_DATA_W-1:0] hval);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IMAGE_WIDTH;
        cfg_wdata <= wval;
        @(posedge clk);
        width_reg = wval[WIDTH_REG_W-1:0];
        cfg_index <= CFG_IMAGE_HEIGHT;
        cfg_wdata <= hval;
        @(posedge clk);
        height_reg = hval[HEIGHT_REG_W-1:0];
        cfg_we <= 1'b0;
        geometries++;
    endtask

    task automatic drive_pixel(input logic [PIX_W-1:0] px, input logic fs,
                               input bit typed, input mean_res_t want);
        mean_res_t predicted;
        bit        emits;

        while ($urandom_range(99) < src_idle_pct)
        begin
            pix.valid <= 1'b0;
            @(posedge clk);
        end
        pix.valid       <= 1'b1;
        pix.pixel       <= px;
        pix.frame_start <= fs;
        do
            @(posedge clk);
        while (!pix.ready);

        emits = mean_of_window(px, fs, predicted);
        pixels_sent++;
        if (typed)
            expected_means.push_back(want);
        else if (emits)
            expected_means.push_back(predicted);
    endtask

    task automatic drain_results();
        pix.valid <= 1'b0;
        while (expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIX_W-1:0] random_pixel();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    task automatic run_phase(input logic [CFG_DATA_W-1:0] wval,
                             input logic [CFG_DATA_W-1:0] hval,
                             input int unsigned src, input int unsigned snk,
                             input bit fresh, input bit restarts, input int count);
        logic      fs;
        mean_res_t none;

        none          = '0;
        src_idle_pct  = src;
        snk_stall_pct = snk;
        set_geometry(wval, hval);
        for (int i = 0; i < count; i++)
        begin
            fs = (fresh && i == 0) || (restarts && $urandom_range(39) == 0);
            drive_pixel(random_pixel(), fs, 1'b0, none);
        end
        drain_results();
    endtask

    task automatic check_mean();
        mean_res_t want;

        means_checked++;
        if (expected_means.size() == 0)
        begin
            note_mismatch($sformatf("unexpected transfer mean %0h row %0d col %0d",
                                    res.mean_value, res.out_row, res.out_col));
            return;
        end
        want = expected_means.pop_front();
        if (res.mean_value !== want.mean)
            note_mismatch($sformatf("mean_value %0h, want %0h at row %0d col %0d",
                                    res.mean_value, want.mean, want.row, want.col));
        if (res.out_row !== want.row)
            note_mismatch($sformatf("out_row %0d, want %0d", res.out_row, want.row));
        if (res.out_col !== want.col)
            note_mismatch($sformatf("out_col %0d, want %0d", res.out_col, want.col));
        if (res.last !== want.last)
            note_mismatch($sformatf("last %0b, want %0b at row %0d col %0d",
                                    res.last, want.last, want.row, want.col));
    endtask

    // result side: sample at the edge, then pick ready for the next cycle
    initial
    begin
        res.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res.valid && res.ready)
                check_mean();
            res.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial
    begin
        mean_res_t want;

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        pixels_sent   = 0;
        means_checked = 0;
        geometries    = 0;
        mismatches    = 0;
        rst_n           <= 1'b0;
        pix.valid       <= 1'b0;
        pix.pixel       <= '0;
        pix.frame_start <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_IMAGE_WIDTH;
        cfg_wdata       <= '0;
        reset_model();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // width and height below range both act as 3
        set_geometry(16'd0, 16'd1);
        foreach (smoke_rows[i])
        begin
            want = '{smoke_rows[i].mean, smoke_rows[i].row, smoke_rows[i].col,
                     smoke_rows[i].last};
            drive_pixel(smoke_rows[i].pixel, smoke_rows[i].frame_start,
                        smoke_rows[i].typed, want);
        end
        drain_results();

        run_phase(16'd12,    16'd6,     0,  0,  1'b1, 1'b1, 120);
        // narrower and shorter in the middle of a frame
        run_phase(16'd5,     16'd3,     87, 0,  1'b0, 1'b0, 100);
        // bits above the width register are dropped
        run_phase(16'hF007,  16'd2,     0,  87, 1'b1, 1'b1, 100);
        run_phase(16'd3,     16'hFFFF,  15, 15, 1'b1, 1'b0, 90);
        run_phase(16'd3,     16'd4,     15, 15, 1'b0, 1'b1, 70);
        // widest line, start of a frame
        run_phase(16'h1FFF,  16'd3,     0,  0,  1'b1, 1'b0, 52);

        if (expected_means.size() != 0)
            note_mismatch($sformatf("%0d means never arrived", expected_means.size()));

        $display("%0d pixels over %0d geometries, %0d window means checked, %0d mismatches",
                 pixels_sent, geometries, means_checked, mismatches);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bf_pkg.sv
rtl/bf_pix_if.sv
rtl/bf_res_if.sv
rtl/bf_line_store.sv
rtl/bf_col_cell.sv
rtl/box_filter_3x3_stream_core.sv
sim/tb_box_filter_3x3_stream_core.sv
